// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold on every clock edge outside reset
`define SPC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// implication checked on every clock edge outside reset
`define SPC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define SPC_ASSERT(label, clk, rstn, prop)
`define SPC_ASSERT_IMPL(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/spc_pkg.sv =====
// types, codes and helpers of the stepper position controller
package spc_pkg;

    localparam int POS_W  = 16;
    localparam int TIME_W = 20;
    localparam int COIL_W = 4;
    localparam int OP_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_GOTO = 2'd1,
        OP_STOP = 2'd2,
        OP_RSVD = 2'd3
    } spc_op_t;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd2;

    localparam logic signed [POS_W-1:0] RANGE_LOW_RST     = -16'sd200;
    localparam logic signed [POS_W-1:0] RANGE_HIGH_RST    = 16'sd200;
    localparam logic [TIME_W-1:0]       STEP_INTERVAL_RST = 20'd5000;

    typedef struct packed {
        logic signed [POS_W-1:0] range_low;
        logic signed [POS_W-1:0] range_high;
        logic [TIME_W-1:0]       step_interval;
    } spc_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
        logic [TIME_W-1:0]       elapsed;
        logic [COIL_W-1:0]       coils;
    } spc_state_t;

    typedef struct packed {
        logic [COIL_W-1:0]       coils;
        logic signed [POS_W-1:0] current_position;
        logic                    moving;
        logic                    stepped;
    } spc_result_t;

    // full-step phase pattern, pin1..pin4 msb first
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            2'd3:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/stepper_position_controller_top.sv =====
// top level of the full-step stepper position controller
//
// input channel s_*: one beat per command, opcode tick (one microsecond),
// goto (target in s_position) or stop (target becomes the current position);
// the target is clamped if range_low < range_high. opcode 3 only re-clamps it.
// result channel m_*: exactly one beat per input beat, in order, carrying
// the coil drive, the position after the command, moving and stepped.
// configuration: cfg_wr_en/cfg_index/cfg_data write range_low (0),
// range_high (1) and step_interval (2); they are to be written only while
// idle, a rule for the user that the block itself does not enforce.
// throughput: one beat per cycle while s_ready is high; the whole step rule
// (clamp, saturating time compare, +/-1 step, coil lookup) is one pass of
// combinational logic that updates the state registers at the accepting edge.
// stall: a two-entry result queue sits before m_*, so a new beat is taken
// while one result waits; s_ready drops only when both entries are full.
// reset (aresetn low, synchronous): position, target, elapsed time and coils
// go to zero, range registers to -200/200, step_interval to 5000, queue empty.
module stepper_position_controller_top
    import spc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_opcode,
    input  logic signed [POS_W-1:0] s_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COIL_W-1:0]       m_coils,
    output logic signed [POS_W-1:0] m_current_position,
    output logic                    m_moving,
    output logic                    m_stepped
);

`include "assert_macros.svh"

    spc_cfg_t    cfg_reg;
    spc_state_t  state_reg;
    spc_state_t  state_next;
    spc_result_t step_result;
    spc_result_t out_result;
    logic        in_beat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_low     <= RANGE_LOW_RST;
            cfg_reg.range_high    <= RANGE_HIGH_RST;
            cfg_reg.step_interval <= STEP_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RANGE_LOW:     cfg_reg.range_low     <= cfg_data[POS_W-1:0];
                REG_RANGE_HIGH:    cfg_reg.range_high    <= cfg_data[POS_W-1:0];
                REG_STEP_INTERVAL: cfg_reg.step_interval <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_beat = s_valid && s_ready;

    // combinational step rule
    spc_step_core u_core (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .opcode     (s_opcode),
        .position   (s_position),
        .state_next (state_next),
        .result     (step_result)
    );

    // motor state advances only on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_beat) begin
            state_reg <= state_next;
        end
    end

    // result queue decouples the receiver
    spc_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (step_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_coils            = out_result.coils;
    assign m_current_position = out_result.current_position;
    assign m_moving           = out_result.moving;
    assign m_stepped          = out_result.stepped;

    // position only moves on an accepted beat, and by one step at most
    `SPC_ASSERT_IMPL(a_pos_needs_beat, aclk, aresetn,
        state_reg.position != $past(state_reg.position), $past(in_beat))
    `SPC_ASSERT_IMPL(a_step_is_unit, aclk, aresetn,
        state_reg.position != $past(state_reg.position),
        (state_reg.position - $past(state_reg.position) == 16'sd1) ||
        ($past(state_reg.position) - state_reg.position == 16'sd1))
    // a stepping result shows the coil pattern of its own position
    `SPC_ASSERT_IMPL(a_step_coils, aclk, aresetn, m_valid && m_stepped,
        m_coils == coil_pattern(m_current_position[1:0]))
    // a step is only reported on a tick beat
    `SPC_ASSERT_IMPL(a_step_on_tick, aclk, aresetn, in_beat && step_result.stepped,
        s_opcode == OP_TICK)

endmodule

// ===== rtl/spc_step_core.sv =====
// next-state and result logic for one beat
module spc_step_core
    import spc_pkg::*;
(
    input  spc_cfg_t                cfg,
    input  spc_state_t              state_cur,
    input  logic [OP_W-1:0]         opcode,
    input  logic signed [POS_W-1:0] position,
    output spc_state_t              state_next,
    output spc_result_t             result
);

    logic signed [POS_W-1:0] tgt_sel;
    logic signed [POS_W-1:0] tgt_clamped;
    logic                    is_tick;
    logic [TIME_W-1:0]       elapsed_inc;
    logic                    fire;
    logic signed [POS_W-1:0] pos_new;

    always_comb begin
        case (opcode)
            OP_GOTO: tgt_sel = position;
            OP_STOP: tgt_sel = state_cur.position;
            default: tgt_sel = state_cur.target;
        endcase
    end

    // clamp only with a proper range
    always_comb begin
        tgt_clamped = tgt_sel;
        if (cfg.range_low < cfg.range_high) begin
            if (tgt_sel < cfg.range_low) begin
                tgt_clamped = cfg.range_low;
            end else if (tgt_sel > cfg.range_high) begin
                tgt_clamped = cfg.range_high;
            end
        end
    end

    assign is_tick = (opcode == OP_TICK);

    // elapsed time saturates at the interval
    assign elapsed_inc = (state_cur.elapsed < cfg.step_interval) ?
                         state_cur.elapsed + 1'b1 : state_cur.elapsed;

    assign fire = is_tick && (tgt_clamped != state_cur.position) &&
                  (elapsed_inc >= cfg.step_interval);

    assign pos_new = (tgt_clamped > state_cur.position) ?
                     state_cur.position + 16'sd1 : state_cur.position - 16'sd1;

    always_comb begin
        state_next        = state_cur;
        state_next.target = tgt_clamped;
        if (is_tick) begin
            state_next.elapsed = elapsed_inc;
        end
        if (fire) begin
            state_next.elapsed  = '0;
            state_next.position = pos_new;
            state_next.coils    = coil_pattern(pos_new[1:0]);
        end
    end

    assign result.coils            = state_next.coils;
    assign result.current_position = state_next.position;
    assign result.moving           = (state_next.target != state_next.position);
    assign result.stepped          = fire;

endmodule

// ===== rtl/spc_out_fifo.sv =====
// two-entry result queue between the step logic and the output port
module spc_out_fifo
    import spc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  spc_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output spc_result_t out_data
);

    spc_result_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== tb/stepper_position_controller_top_test.sv =====
// self-checking testbench of the stepper position controller with random stalls
`timescale 1ns / 100ps

module stepper_position_controller_top_test;
    import spc_pkg::*;

    // generous ceiling on run length, well above the slowest correct run
    localparam int CYCLE_LIMIT = 600000;
    // random command beats per configuration phase
    localparam int PHASE_BEATS = 140;
    localparam int PHASES      = 12;

    typedef struct {
        spc_op_t                 op;
        logic signed [POS_W-1:0] pos;
    } motor_cmd_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_opcode;
    logic signed [POS_W-1:0] s_position;
    logic                    m_valid;
    logic                    m_ready;
    logic [COIL_W-1:0]       m_coils;
    logic signed [POS_W-1:0] m_current_position;
    logic                    m_moving;
    logic                    m_stepped;

    // commands waiting to go out, and motor results still owed by the block
    motor_cmd_t  commands_to_send[$];
    spc_result_t motor_results_due[$];

    // shadow of the range and interval registers
    logic signed [POS_W-1:0] lim_low;
    logic signed [POS_W-1:0] lim_high;
    logic [TIME_W-1:0]       step_gap;

    // shadow of the motor state
    logic signed [POS_W-1:0] motor_pos;
    logic signed [POS_W-1:0] motor_target;
    logic [TIME_W-1:0]       motor_elapsed;
    logic [COIL_W-1:0]       motor_coils;

    int cycle_count;
    int errors;
    int n_queued;
    int send_gap;
    int sink_gap;
    bit calm;        // no idling on either side in the closing phase
    bit cmd_taken;   // input beat accepted at the last rising edge

    stepper_position_controller_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_position         (s_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_coils            (m_coils),
        .m_current_position (m_current_position),
        .m_moving           (m_moving),
        .m_stepped          (m_stepped)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one command applied to the shadow state: the opcode acts, the target is
    // pulled into the range, then a tick advances time and may take a step
    function automatic spc_result_t next_motor_result(input spc_op_t op,
                                                      input logic signed [POS_W-1:0] req);
        spc_result_t r;
        logic        did_step;
        did_step = 1'b0;
        if (op == OP_GOTO) begin
            motor_target = req;
        end else if (op == OP_STOP) begin
            motor_target = motor_pos;
        end
        // an empty or inverted range leaves the target alone
        if (lim_low < lim_high) begin
            if (motor_target < lim_low) motor_target = lim_low;
            if (motor_target > lim_high) motor_target = lim_high;
        end
        if (op == OP_TICK) begin
            // elapsed time holds at the interval once reached
            if (motor_elapsed < step_gap) motor_elapsed = motor_elapsed + 1'b1;
            if (motor_target != motor_pos && motor_elapsed >= step_gap) begin
                motor_elapsed = '0;
                if (motor_target > motor_pos) motor_pos = motor_pos + 16'sd1;
                else motor_pos = motor_pos - 16'sd1;
                // phase from the low two bits keeps the sequence smooth across zero
                case (motor_pos[1:0])
                    2'd0: motor_coils = 4'b1010;
                    2'd1: motor_coils = 4'b0110;
                    2'd2: motor_coils = 4'b0101;
                    default: motor_coils = 4'b1001;
                endcase
                did_step = 1'b1;
            end
        end
        r.coils            = motor_coils;
        r.current_position = motor_pos;
        r.moving           = (motor_target != motor_pos);
        r.stepped          = did_step;
        return r;
    endfunction

    // rising edge: count cycles, note the input beat, check result beats
    always @(posedge aclk) begin : watch
        spc_result_t got;
        spc_result_t want;
        cycle_count = cycle_count + 1;
        cmd_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            got.coils            = m_coils;
            got.current_position = m_current_position;
            got.moving           = m_moving;
            got.stepped          = m_stepped;
            if (motor_results_due.size() == 0) begin
                errors = errors + 1;
                $display("%0t: result beat with nothing expected, actual coils %b pos %0d moving %b stepped %b",
                         $time, got.coils, got.current_position, got.moving, got.stepped);
            end else begin
                want = motor_results_due.pop_front();
                if (got !== want) begin
                    errors = errors + 1;
                    $display("%0t: mismatch, expected coils %b pos %0d moving %b stepped %b",
                             $time, want.coils, want.current_position, want.moving, want.stepped);
                    $display("%0t:           actual coils %b pos %0d moving %b stepped %b",
                             $time, got.coils, got.current_position, got.moving, got.stepped);
                end
            end
        end
        // the beat taken at this edge owes one result, predicted in order
        if (cmd_taken) begin
            motor_results_due.push_back(next_motor_result(spc_op_t'(s_opcode), s_position));
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // falling edge: command driver, holds a beat until it is taken
    always @(negedge aclk) begin : feed
        motor_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || cmd_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (commands_to_send.size() != 0) begin
                c = commands_to_send.pop_front();
                s_valid    <= 1'b1;
                s_opcode   <= c.op;
                s_position <= c.pos;
                // occasional idle burst after a beat
                if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // falling edge: result sink with random stall bursts
    always @(negedge aclk) begin : drain
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 11) == 0) sink_gap = $urandom_range(1, 16);
        end
    end

    task automatic queue_cmd(input spc_op_t op, input logic signed [POS_W-1:0] pos);
        motor_cmd_t c;
        c.op  = op;
        c.pos = pos;
        commands_to_send.push_back(c);
        n_queued = n_queued + 1;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_cmd(OP_TICK, 16'($urandom_range(0, 65535)));
    endtask

    // wait until every command is out and every result is back, then a short pause
    task automatic settle();
        while (commands_to_send.size() != 0 || s_valid || motor_results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // write all three registers while idle, upper data bits of the range writes as noise
    task automatic set_limits(input logic signed [POS_W-1:0] lo,
                              input logic signed [POS_W-1:0] hi,
                              input logic [TIME_W-1:0] gap);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RANGE_LOW;
        cfg_data  <= {4'($urandom_range(0, 15)), lo};
        @(negedge aclk);
        cfg_index <= REG_RANGE_HIGH;
        cfg_data  <= {4'($urandom_range(0, 15)), hi};
        @(negedge aclk);
        cfg_index <= REG_STEP_INTERVAL;
        cfg_data  <= gap;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        lim_low  = lo;
        lim_high = hi;
        step_gap = gap;
    endtask

    initial begin : main
        int ph;
        int stop_at;
        int lo;
        int hi;
        int gap;
        // every input known from time zero, reset held low
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_RANGE_LOW;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_opcode   = OP_TICK;
        s_position = '0;
        m_ready    = 1'b0;
        cycle_count = 0;
        errors      = 0;
        n_queued    = 0;
        send_gap    = 0;
        sink_gap    = 0;
        calm        = 1'b0;
        cmd_taken   = 1'b0;
        lim_low       = RANGE_LOW_RST;
        lim_high      = RANGE_HIGH_RST;
        step_gap      = STEP_INTERVAL_RST;
        motor_pos     = '0;
        motor_target  = '0;
        motor_elapsed = '0;
        motor_coils   = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: goto beyond the high limit, a tick too early to step
        queue_cmd(OP_GOTO, 16'sd300);
        queue_cmd(OP_TICK, 16'sd0);
        settle();

        // zero interval, narrow range: extreme targets get clamped, step every tick
        set_limits(-16'sd4, 16'sd4, 20'd0);
        @(posedge aclk);
        queue_cmd(OP_GOTO, 16'sh7FFF);
        queue_ticks(5);
        // reserved opcode only re-clamps
        queue_cmd(OP_RSVD, 16'sh8000);
        queue_cmd(OP_GOTO, 16'sh8000);
        queue_ticks(3);
        queue_cmd(OP_STOP, 16'sh7FFF);
        queue_ticks(1);
        settle();

        // inverted range: no clamp; idle ticks saturate elapsed, next step is immediate
        set_limits(16'sd3, -16'sd3, 20'd2);
        @(posedge aclk);
        queue_cmd(OP_GOTO, -16'sd7);
        queue_ticks(2);
        queue_cmd(OP_STOP, 16'sd0);
        queue_ticks(3);
        queue_cmd(OP_GOTO, 16'sd5);
        queue_ticks(1);
        settle();

        // stop while outside the range: target pulled back in, motor moves
        set_limits(16'sd20, 16'sd30, 20'd1);
        @(posedge aclk);
        queue_cmd(OP_STOP, 16'sd0);
        queue_ticks(1);
        settle();

        // random phases, each with its own register settings
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                lo = -32768; hi = 32767; gap = 1;
            end else if (ph == 1) begin
                lo = 32767; hi = -32768; gap = 20'hFFFFF;
            end else begin
                case ($urandom_range(0, 4))
                    0: begin
                        lo = -int'($urandom_range(0, 60));
                        hi = int'($urandom_range(0, 60));
                    end
                    1: begin
                        lo = int'($urandom_range(0, 80)) - 40;
                        hi = lo;
                    end
                    2: begin
                        lo = int'($urandom_range(1, 60));
                        hi = -int'($urandom_range(0, 60));
                    end
                    3: begin
                        lo = int'($urandom_range(10, 30));
                        hi = lo + int'($urandom_range(5, 30));
                        if ($urandom_range(0, 1) == 1) begin
                            lo = -hi;
                            hi = lo + int'($urandom_range(5, 30));
                        end
                    end
                    default: begin
                        lo = int'($urandom_range(0, 65535)) - 32768;
                        hi = int'($urandom_range(0, 65535)) - 32768;
                    end
                endcase
                case ($urandom_range(0, 3))
                    0: gap = 0;
                    1: gap = 1;
                    2: gap = $urandom_range(2, 6);
                    default: gap = $urandom_range(0, 20);
                endcase
            end
            // closing phase runs with no idling at all
            if (ph == PHASES - 1) calm = 1'b1;
            set_limits(16'(lo), 16'(hi), 20'(gap));
            @(posedge aclk);
            stop_at = n_queued + PHASE_BEATS;
            while (n_queued < stop_at) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        // move to a nearby target and give it ticks to get there
                        queue_cmd(OP_GOTO, 16'(int'($urandom_range(0, 120)) - 60));
                        queue_ticks($urandom_range(1, 24));
                    end
                    5: begin
                        queue_cmd(OP_STOP, 16'($urandom_range(0, 65535)));
                        queue_ticks($urandom_range(1, 12));
                    end
                    6: queue_ticks($urandom_range(10, 40));
                    7: begin
                        queue_cmd(OP_GOTO, 16'($urandom_range(0, 65535)));
                        queue_ticks($urandom_range(1, 8));
                    end
                    8: queue_cmd(OP_RSVD, 16'($urandom_range(0, 65535)));
                    default: queue_cmd(spc_op_t'($urandom_range(0, 3)),
                                       16'($urandom_range(0, 65535)));
                endcase
            end
            settle();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== stepper_position_controller_top.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_step_core.sv
rtl/spc_out_fifo.sv
rtl/stepper_position_controller_top.sv
tb/stepper_position_controller_top_test.sv
